[sv/assert_macros.svh]
// Assertion macros shared by the console RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define TCW_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked property that is checked through reset as well.
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/tcw_pkg.sv]
// Shared constants, codes and types of the text console writer.
// No dependencies; used by every tcw_* module and the top level.
`timescale 1ns / 1ps

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ADDR_W    = $clog2(CELLS);

    // Field widths of the beats
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int LOC_W    = 11;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = ATTR_W + CHAR_W;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_MAX    = 8'h7F;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_cmd_t;

    typedef struct packed {
        logic home;
        logic newline;
        logic advance;
    } cur_cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] loc;
        logic              scroll;
    } cur_stat_t;

endpackage

[sv/tcw_buffer.sv]
// Cell buffer: one write port, one registered read port.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_buffer (
    input  logic                         aclk,
    input  tcw_pkg::mem_cmd_t            mem_cmd,
    output logic [tcw_pkg::CELL_W-1:0]   rd_data
);

    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_cmd.we) begin
            mem[mem_cmd.waddr] <= mem_cmd.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_cmd.re) begin
            rd_data_reg <= mem[mem_cmd.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/tcw_cursor.sv]
// Cursor column, row and linear location, updated per command.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_cursor (
    input  logic                aclk,
    input  logic                aresetn,
    input  tcw_pkg::cur_cmd_t   cmd,
    output tcw_pkg::cur_stat_t  stat
);

    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tcw_pkg::ADDR_W-1:0] loc_reg, loc_next;
    logic                       at_last_row;
    logic                       at_row_end;
    logic                       line_end;

    always_comb begin
        at_last_row = (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
        at_row_end  = (col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
        line_end    = cmd.newline || (cmd.advance && at_row_end);
        col_next    = col_reg;
        row_next    = row_reg;
        loc_next    = loc_reg;
        if (cmd.home) begin
            col_next = '0;
            row_next = '0;
            loc_next = '0;
        end else if (line_end) begin
            col_next = '0;
            if (at_last_row) begin
                // scroll keeps the cursor on the bottom row
                loc_next = tcw_pkg::ADDR_W'(tcw_pkg::LAST_BASE);
            end else begin
                row_next = row_reg + 1'b1;
                loc_next = loc_reg - tcw_pkg::ADDR_W'(col_reg)
                         + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
            end
        end else if (cmd.advance) begin
            col_next = col_reg + 1'b1;
            loc_next = loc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            loc_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            loc_reg <= loc_next;
        end
    end

    assign stat.loc    = loc_reg;
    assign stat.scroll = line_end && at_last_row;

endmodule

[sv/tcw_ctrl.sv]
// Sequencer: decodes one item, runs the shared sweep counter for clear and
// scroll, and drives the buffer and cursor. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tcw_pkg::ACTION_W-1:0]   in_action,
    input  logic [tcw_pkg::CHAR_W-1:0]     in_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]    in_cell_index,
    input  logic [tcw_pkg::ATTR_W-1:0]     attr,
    input  logic                           out_free,
    input  tcw_pkg::cur_stat_t             cur_stat,
    output tcw_pkg::cur_cmd_t              cur_cmd,
    output tcw_pkg::mem_cmd_t              mem_cmd,
    input  logic [tcw_pkg::CELL_W-1:0]     rd_data,
    output logic                           res_load,
    output logic [tcw_pkg::CELL_W-1:0]     res_data
);

    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL =
        tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] COPY_END =
        tcw_pkg::ADDR_W'(tcw_pkg::LAST_BASE);

    tcw_pkg::state_t                state_reg, state_next;
    logic [tcw_pkg::ACTION_W-1:0]   act_reg, act_next;
    logic [tcw_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic [tcw_pkg::INDEX_W-1:0]    idx_reg, idx_next;
    logic                           read_ok_reg, read_ok_next;
    logic [tcw_pkg::ADDR_W-1:0]     cnt_reg, cnt_next;
    logic                           scroll_reg, scroll_next;
    logic [tcw_pkg::ATTR_W-1:0]     sweep_attr_reg, sweep_attr_next;
    logic                           has_result_reg, has_result_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [tcw_pkg::ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic                           pend_ram_reg, pend_ram_next;
    logic                           printable;
    logic                           newline;
    logic                           sweep_copy;

    always_comb begin
        printable  = char_reg inside {[tcw_pkg::SPACE_CHAR : tcw_pkg::PRINT_MAX]};
        newline    = (char_reg == tcw_pkg::NEWLINE_CHAR);
        sweep_copy = scroll_reg && (cnt_reg < COPY_END);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcw_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                if (act_reg == tcw_pkg::ACT_CLEAR ||
                    (act_reg == tcw_pkg::ACT_PUT && cur_stat.scroll)) begin
                    state_next = tcw_pkg::ST_SWEEP;
                end else begin
                    state_next = tcw_pkg::ST_FINISH;
                end
            end
            tcw_pkg::ST_SWEEP: begin
                if (cnt_reg == LAST_CELL) begin
                    state_next = tcw_pkg::ST_DRAIN;
                end
            end
            tcw_pkg::ST_DRAIN: begin
                state_next = has_result_reg ? tcw_pkg::ST_FINISH : tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default: state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready      = 1'b0;
        res_load      = 1'b0;
        cur_cmd       = '0;
        mem_cmd.we    = pend_valid_reg;
        mem_cmd.waddr = pend_addr_reg;
        mem_cmd.wdata = pend_ram_reg ? rd_data : {sweep_attr_reg, tcw_pkg::SPACE_CHAR};
        mem_cmd.re    = 1'b0;
        mem_cmd.raddr = cnt_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        case (state_reg)
            tcw_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            tcw_pkg::ST_EXEC: begin
                case (act_reg)
                    tcw_pkg::ACT_PUT: begin
                        if (printable) begin
                            mem_cmd.we      = 1'b1;
                            mem_cmd.waddr   = cur_stat.loc;
                            mem_cmd.wdata   = {attr, char_reg};
                            cur_cmd.advance = 1'b1;
                        end else if (newline) begin
                            cur_cmd.newline = 1'b1;
                        end
                    end
                    tcw_pkg::ACT_CLEAR: begin
                        cur_cmd.home = 1'b1;
                    end
                    tcw_pkg::ACT_READ: begin
                        mem_cmd.re    = read_ok_reg;
                        mem_cmd.raddr = tcw_pkg::ADDR_W'(idx_reg);
                    end
                    default: ;
                endcase
            end
            tcw_pkg::ST_SWEEP: begin
                mem_cmd.re = sweep_copy;
            end
            tcw_pkg::ST_FINISH: begin
                res_load = out_free;
            end
            default: ;
        endcase
        res_data = read_ok_reg ? rd_data : '0;
    end

    // datapath registers
    always_comb begin
        act_next        = act_reg;
        char_next       = char_reg;
        idx_next        = idx_reg;
        read_ok_next    = read_ok_reg;
        scroll_next     = scroll_reg;
        sweep_attr_next = sweep_attr_reg;
        has_result_next = has_result_reg;
        cnt_next        = '0;
        pend_valid_next = 1'b0;
        pend_addr_next  = cnt_reg;
        pend_ram_next   = sweep_copy;
        if (state_reg == tcw_pkg::ST_IDLE && in_valid) begin
            act_next     = in_action;
            char_next    = in_char_code;
            idx_next     = in_cell_index;
            read_ok_next = (in_action == tcw_pkg::ACT_READ) &&
                           (32'(in_cell_index) < tcw_pkg::CELLS);
        end
        if (state_reg == tcw_pkg::ST_EXEC) begin
            scroll_next     = (act_reg == tcw_pkg::ACT_PUT);
            sweep_attr_next = attr;
            has_result_next = 1'b1;
        end
        if (state_reg == tcw_pkg::ST_SWEEP) begin
            // one cell per cycle; the write lands in the cycle after the read
            cnt_next        = cnt_reg + 1'b1;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // power-up clearing pass through the whole buffer
            state_reg      <= tcw_pkg::ST_SWEEP;
            cnt_reg        <= '0;
            scroll_reg     <= 1'b0;
            sweep_attr_reg <= tcw_pkg::ATTR_RESET;
            has_result_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            read_ok_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            scroll_reg     <= scroll_next;
            sweep_attr_reg <= sweep_attr_next;
            has_result_reg <= has_result_next;
            pend_valid_reg <= pend_valid_next;
            read_ok_reg    <= read_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        char_reg      <= char_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        pend_ram_reg  <= pend_ram_next;
    end

endmodule

[sv/text_console_writer.sv]
// Text console writer, top level: attribute register, result register,
// sequencer, cursor and cell buffer. Depends on tcw_pkg, tcw_ctrl,
// tcw_cursor, tcw_buffer and assert_macros.svh.
//
// A character-cell console of 80 x 25 cells of 16 bits (attribute above
// character). Each input beat is one action: put a byte, clear the screen or
// read a cell, and yields exactly one result beat with the linear cursor
// location and, for a read, the cell. A put, read or ignored byte runs from
// accept through the exec and finish states back to idle; a clear, and a put
// that scrolls the screen, also run the sweep, which moves one cell per cycle
// through the single write port of the cell memory. After reset the block
// runs a clearing pass with s_ready low; attribute writes are taken at
// any time. While a result beat waits on m_ready the next input beat is
// still accepted and processed up to its own result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_console_writer (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input beats
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tcw_pkg::ACTION_W-1:0]   s_action,
    input  logic [tcw_pkg::CHAR_W-1:0]     s_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]    s_cell_index,
    // result beats
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tcw_pkg::LOC_W-1:0]      m_cursor_location,
    output logic [tcw_pkg::CELL_W-1:0]     m_cell_data,
    // attribute register
    input  logic                           cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]     cfg_wr_data
);

    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic                       m_valid_reg;
    logic [tcw_pkg::LOC_W-1:0]  m_loc_reg;
    logic [tcw_pkg::CELL_W-1:0] m_data_reg;
    logic                       out_free;
    logic                       res_load;
    logic [tcw_pkg::CELL_W-1:0] res_data;
    logic [tcw_pkg::CELL_W-1:0] rd_data;
    tcw_pkg::cur_cmd_t          cur_cmd;
    tcw_pkg::cur_stat_t         cur_stat;
    tcw_pkg::mem_cmd_t          mem_cmd;

    // Attribute applies to later writes, clears and scrolls only.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= tcw_pkg::ATTR_RESET;
        end else if (cfg_wr_en) begin
            attr_reg <= cfg_wr_data;
        end
    end

    // The result register is free when empty or drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    tcw_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_action     (s_action),
        .in_char_code  (s_char_code),
        .in_cell_index (s_cell_index),
        .attr          (attr_reg),
        .out_free      (out_free),
        .cur_stat      (cur_stat),
        .cur_cmd       (cur_cmd),
        .mem_cmd       (mem_cmd),
        .rd_data       (rd_data),
        .res_load      (res_load),
        .res_data      (res_data)
    );

    tcw_cursor u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cur_cmd),
        .stat    (cur_stat)
    );

    tcw_buffer u_buffer (
        .aclk    (aclk),
        .mem_cmd (mem_cmd),
        .rd_data (rd_data)
    );

    // Hold the result beat until taken; load a new one when the sequencer
    // finishes an item, drop valid once the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_loc_reg  <= tcw_pkg::LOC_W'(cur_stat.loc);
            m_data_reg <= res_data;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_location = m_loc_reg;
    assign m_cell_data       = m_data_reg;

    // No buffer write may be in flight while the block waits for a beat.
    `TCW_ASSERT(a_idle_no_write, aclk, aresetn, s_ready |-> !mem_cmd.we, "write while idle")
    // The cursor never points outside the buffer.
    `TCW_ASSERT(a_loc_range, aclk, aresetn, (32'(cur_stat.loc) < tcw_pkg::CELLS), "cursor out of range")
    // A finished item never overwrites a result beat that is still waiting.
    `TCW_ASSERT(a_no_overrun, aclk, aresetn, res_load |-> (!m_valid_reg || m_ready), "result overrun")
    // Reset empties the result register and starts the clearing pass.
    `TCW_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> (!m_valid && !s_ready), "bad reset state")

endmodule
